/* hw/rtl/nsfq_pkg.sv */
// Shared constants and types for the NMEA sentence framer queue.
// Used by nsfq_ctrl, nsfq_mem, nmea_sentence_framer_queue and tb_top; depends on nothing.
`default_nettype none

package nsfq_pkg;

  // Defaults for the top-level parameters
  localparam int SLOTS_DEF   = 8;
  localparam int MAX_LEN_DEF = 82;

  // Framing characters
  localparam logic [7:0] START_CHAR = 8'h24;  // '$'
  localparam logic [7:0] END_CHAR   = 8'h0A;  // line feed

  // Field widths fixed by the stream format
  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int OFFSET_W = 7;
  localparam int OUTLEN_W = 7;

  // Operation codes carried in in_tuser
  localparam logic [OP_W-1:0] OP_RX   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_POP  = 2'd2;

  // Per-word status produced by the framer control
  typedef struct packed {
    logic done;         // this byte closed a sentence
    logic rd_req;       // read of a non-empty queue, offset still to be checked
    logic queue_empty;  // after this word
    logic overflow;     // sticky, after this word
    logic too_long;     // sticky, after this word
  } ctrl_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/nsfq_ctrl.sv */
// Framer control: hunt/fill state, ring pointers, sticky flags, memory requests.
// Depends on nsfq_pkg.
`default_nettype none

module nsfq_ctrl #(
  parameter int SLOTS   = nsfq_pkg::SLOTS_DEF,
  parameter int MAX_LEN = nsfq_pkg::MAX_LEN_DEF,
  localparam int SLOT_W = $clog2(SLOTS),
  localparam int LEN_W  = $clog2(MAX_LEN + 1),
  localparam int ADDR_W = $clog2(SLOTS * MAX_LEN)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic [nsfq_pkg::OP_W-1:0]     op,
  input  wire logic [nsfq_pkg::BYTE_W-1:0]   rx_byte,
  input  wire logic [nsfq_pkg::OFFSET_W-1:0] read_offset,
  output nsfq_pkg::ctrl_stat_t               stat,
  output logic [LEN_W-1:0]                   sent_len,
  output logic                               wr_en,
  output logic [ADDR_W-1:0]                  wr_addr,
  output logic [nsfq_pkg::BYTE_W-1:0]        wr_data,
  output logic                               len_wr_en,
  output logic [SLOT_W-1:0]                  len_wr_slot,
  output logic [ADDR_W-1:0]                  rd_addr,
  output logic [SLOT_W-1:0]                  rd_slot
);

  logic [SLOT_W-1:0] ws_r, ws_nxt;
  logic [SLOT_W-1:0] rs_r, rs_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic              ovf_r, ovf_nxt;
  logic              tl_r, tl_nxt;
  logic              empty;
  logic [LEN_W-1:0]  fill_inc;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  assign empty    = (rs_r == ws_r);
  assign fill_inc = fill_r + 1'b1;

  // Compute next state and memory requests for the word on the input
  always_comb begin
    ws_nxt      = ws_r;
    rs_nxt      = rs_r;
    fill_nxt    = fill_r;
    ovf_nxt     = ovf_r;
    tl_nxt      = tl_r;
    wr_en       = 1'b0;
    wr_data     = rx_byte;
    len_wr_en   = 1'b0;
    stat.done   = 1'b0;
    stat.rd_req = 1'b0;
    case (op)
      nsfq_pkg::OP_RX: begin
        if (fill_r == '0) begin
          // hunt for the start character
          if (rx_byte == nsfq_pkg::START_CHAR) begin
            wr_en    = 1'b1;
            wr_data  = nsfq_pkg::START_CHAR;
            fill_nxt = LEN_W'(1);
          end
        end else if (fill_r >= LEN_W'(MAX_LEN)) begin
          // drop the sentence, it does not fit its buffer
          tl_nxt   = 1'b1;
          fill_nxt = '0;
        end else begin
          wr_en    = 1'b1;
          fill_nxt = fill_inc;
          if (rx_byte == nsfq_pkg::END_CHAR) begin
            len_wr_en = 1'b1;
            stat.done = 1'b1;
            ws_nxt    = next_slot(ws_r);
            if (next_slot(ws_r) == rs_r) begin
              ovf_nxt = 1'b1;
            end
            fill_nxt = '0;
          end
        end
      end
      nsfq_pkg::OP_READ: begin
        stat.rd_req = !empty;
      end
      nsfq_pkg::OP_POP: begin
        if (!empty) begin
          rs_nxt = next_slot(rs_r);
        end
      end
      default: begin
      end
    endcase
    stat.queue_empty = (rs_nxt == ws_nxt);
    stat.overflow    = ovf_nxt;
    stat.too_long    = tl_nxt;
  end

  // Memory addresses: slot base plus position
  assign wr_addr     = ADDR_W'(ADDR_W'(ws_r) * ADDR_W'(MAX_LEN)) + ADDR_W'(fill_r);
  assign rd_addr     = ADDR_W'(ADDR_W'(rs_r) * ADDR_W'(MAX_LEN)) + ADDR_W'(read_offset);
  assign rd_slot     = rs_r;
  assign len_wr_slot = ws_r;
  assign sent_len    = fill_inc;

  // Advance state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r   <= '0;
      rs_r   <= '0;
      fill_r <= '0;
      ovf_r  <= 1'b0;
      tl_r   <= 1'b0;
    end else if (accept) begin
      ws_r   <= ws_nxt;
      rs_r   <= rs_nxt;
      fill_r <= fill_nxt;
      ovf_r  <= ovf_nxt;
      tl_r   <= tl_nxt;
    end
  end

  // Fill position never passes the buffer size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LEN_W'(MAX_LEN))
    else $error("fill position beyond buffer");

  // Sticky flags never clear outside reset
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (ovf_r || tl_r) |=> ((ovf_r || !$past(ovf_r)) && (tl_r || !$past(tl_r))))
    else $error("sticky flag cleared");

  // A stored byte always lands inside the write slot
  a_wr_in_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && wr_en) |-> (fill_r < LEN_W'(MAX_LEN)))
    else $error("byte written past slot");

endmodule

`default_nettype wire

/* hw/rtl/nsfq_mem.sv */
// Sentence byte store and per-slot length store, registered reads.
// Depends on nsfq_pkg.
`default_nettype none

module nsfq_mem #(
  parameter int SLOTS   = nsfq_pkg::SLOTS_DEF,
  parameter int MAX_LEN = nsfq_pkg::MAX_LEN_DEF,
  localparam int SLOT_W = $clog2(SLOTS),
  localparam int LEN_W  = $clog2(MAX_LEN + 1),
  localparam int ADDR_W = $clog2(SLOTS * MAX_LEN),
  localparam int DEPTH  = SLOTS * MAX_LEN
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [ADDR_W-1:0]           wr_addr,
  input  wire logic [nsfq_pkg::BYTE_W-1:0] wr_data,
  input  wire logic                        len_wr_en,
  input  wire logic [SLOT_W-1:0]           len_wr_slot,
  input  wire logic [LEN_W-1:0]            len_wr_data,
  input  wire logic                        rd_en,
  input  wire logic [ADDR_W-1:0]           rd_addr,
  input  wire logic [SLOT_W-1:0]           rd_slot,
  output logic [nsfq_pkg::BYTE_W-1:0]      rd_data,
  output logic [LEN_W-1:0]                 rd_len
);

  logic [nsfq_pkg::BYTE_W-1:0] store_mem [DEPTH];
  logic [LEN_W-1:0]            len_mem [SLOTS];

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= store_mem[rd_addr];
    end
  end

  // Length store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (len_wr_en) begin
      len_mem[len_wr_slot] <= len_wr_data;
    end
    if (rd_en) begin
      rd_len <= len_mem[rd_slot];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/nmea_sentence_framer_queue.sv */
// NMEA sentence framer with a ring of sentence buffers.
// Top level: instantiates nsfq_ctrl and nsfq_mem; depends on nsfq_pkg.
//
// Input channel (in_*): one word per command. in_tuser is the operation:
// received byte, read one byte of the oldest sentence, or pop it. in_tdata
// carries the received byte and the read offset.
// Output channel (out_*): exactly one result word per input word, in order.
// It reports sentence completion with its length, read data with its valid
// bit, and the queue status (empty, sticky overflow, sticky too-long).
// An accepted word passes the read stage (registered memory read) and then the output
// register before it shows on the output.
// Throughput: one word per cycle while the output is not stalled; the byte store and
// length store are read and written once per cycle, and writes land at the accept edge
// so a read of the following word already sees them.
// Reset (rst_n low, synchronous): pointers, fill position and flags clear and
// the framer hunts for '$'. Buffer contents are not cleared; only completed
// slots are ever read. No clearing pass, the block is ready after reset.
// Stall: while out_tready is low the output and one word in the read stage
// are held; in_tready then drops until the output is taken.
`default_nettype none

module nmea_sentence_framer_queue #(
  parameter int SLOTS   = nsfq_pkg::SLOTS_DEF,
  parameter int MAX_LEN = nsfq_pkg::MAX_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] rx_byte, [14:8] read_offset, [15] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [6:0] sentence_length, [14:7] read_data,
                                       // [15] queue_empty, [16] overflow_flag,
                                       // [17] too_long_flag, [23:18] zero
  output logic [1:0]       out_tuser   // [0] sentence_done, [1] read_valid
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = $clog2(SLOTS * MAX_LEN);
  localparam int CMP_W  = (LEN_W > nsfq_pkg::OFFSET_W) ? LEN_W : nsfq_pkg::OFFSET_W;

  logic                              accept;
  nsfq_pkg::ctrl_stat_t              stat;
  logic [LEN_W-1:0]                  sent_len;
  logic                              wr_en;
  logic [ADDR_W-1:0]                 wr_addr;
  logic [nsfq_pkg::BYTE_W-1:0]       wr_data;
  logic                              len_wr_en;
  logic [SLOT_W-1:0]                 len_wr_slot;
  logic [ADDR_W-1:0]                 rd_addr;
  logic [SLOT_W-1:0]                 rd_slot;
  logic [nsfq_pkg::BYTE_W-1:0]       rd_data;
  logic [LEN_W-1:0]                  rd_len;

  // Read stage registers
  logic                              s1_v_r;
  nsfq_pkg::ctrl_stat_t              s1_stat_r;
  logic [nsfq_pkg::OUTLEN_W-1:0]     s1_len_r;
  logic [nsfq_pkg::OFFSET_W-1:0]     s1_off_r;
  logic                              s1_adv;
  logic                              rd_valid;

  // Output registers
  logic                              out_v_r;
  logic [23:0]                       out_data_r;
  logic [1:0]                        out_user_r;
  logic                              out_load;

  assign out_load  = !out_v_r || out_tready;
  assign s1_adv    = s1_v_r && out_load;
  assign in_tready = rst_n && (!s1_v_r || out_load);
  assign accept    = in_tvalid && in_tready;

  nsfq_ctrl #(
    .SLOTS   (SLOTS),
    .MAX_LEN (MAX_LEN)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .op          (in_tuser),
    .rx_byte     (in_tdata[7:0]),
    .read_offset (in_tdata[14:8]),
    .stat        (stat),
    .sent_len    (sent_len),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .len_wr_en   (len_wr_en),
    .len_wr_slot (len_wr_slot),
    .rd_addr     (rd_addr),
    .rd_slot     (rd_slot)
  );

  nsfq_mem #(
    .SLOTS   (SLOTS),
    .MAX_LEN (MAX_LEN)
  ) u_mem (
    .clk         (clk),
    .wr_en       (wr_en && accept),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .len_wr_en   (len_wr_en && accept),
    .len_wr_slot (len_wr_slot),
    .len_wr_data (sent_len),
    .rd_en       (accept),
    .rd_addr     (rd_addr),
    .rd_slot     (rd_slot),
    .rd_data     (rd_data),
    .rd_len      (rd_len)
  );

  // Hold the accepted word's status while the memory read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_stat_r <= stat;
      s1_len_r  <= stat.done ? nsfq_pkg::OUTLEN_W'(sent_len) : '0;
      s1_off_r  <= in_tdata[14:8];
    end
  end

  // Check the offset against the stored length
  assign rd_valid = s1_stat_r.rd_req && (CMP_W'(s1_off_r) < CMP_W'(rd_len));

  // Load the output register when it is free or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {6'd0, s1_stat_r.too_long, s1_stat_r.overflow, s1_stat_r.queue_empty,
                     (rd_valid ? rd_data : 8'd0), s1_len_r};
      out_user_r <= {rd_valid, s1_stat_r.done};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // A held read stage blocks new input
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |-> !in_tready)
    else $error("input taken while read stage held");

  // Every accepted word reaches the read stage
  a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted word lost");

  // A result never both completes a sentence and returns read data
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("done and read valid together");

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for nmea_sentence_framer_queue: drives command words on the
// input stream, predicts each result word with its own framer model and checks it.
// Depends on nsfq_pkg and the RTL of nmea_sentence_framer_queue only.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS          = nsfq_pkg::SLOTS_DEF;
  localparam int MAX_LEN        = nsfq_pkg::MAX_LEN_DEF;
  localparam int HOLD_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_WORDS   = 370;
  localparam int END_CYCLES     = 6;

  // Spare op code: the block treats it as a no-op
  localparam logic [nsfq_pkg::OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic                          done;
    logic [nsfq_pkg::OUTLEN_W-1:0] length;
    logic [nsfq_pkg::BYTE_W-1:0]   data;
    logic                          valid;
    logic                          empty;
    logic                          overflow;
    logic                          too_long;
  } framer_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] rx_byte, [14:8] read_offset, [15] zero
  logic [1:0]  in_tuser;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [6:0] length, [14:7] read_data, [15] empty, [16] overflow,
                           // [17] too_long, [23:18] zero
  logic [1:0]  out_tuser;  // [0] sentence_done, [1] read_valid

  // Framer state as predicted
  logic [7:0]  line_buf [SLOTS][MAX_LEN];
  int unsigned line_len [SLOTS];
  int unsigned wr_slot;
  int unsigned rd_slot;
  int unsigned fill_pos;
  bit          overflow_seen;
  bit          too_long_seen;

  framer_result_t expected_results[$];
  int sent_count;
  int checked_count;
  int mismatches;
  int idle_cycles;

  bit sender_calm;
  bit receiver_calm;
  bit hold_off_req;
  bit hold_active;

  nmea_sentence_framer_queue #(
    .SLOTS  (SLOTS),
    .MAX_LEN(MAX_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the predicted framer by one command word and return its result word
  function automatic framer_result_t predict_framer(input logic [1:0] op,
                                                    input logic [7:0] rx,
                                                    input logic [6:0] offset);
    framer_result_t r;
    bit             was_empty;
    r = '0;
    was_empty = (rd_slot == wr_slot);
    case (op)
      nsfq_pkg::OP_RX: begin
        if (fill_pos == 0) begin
          // hunt for the start character
          if (rx == nsfq_pkg::START_CHAR) begin
            line_buf[wr_slot][0] = nsfq_pkg::START_CHAR;
            fill_pos = 1;
          end
        end else if (fill_pos >= MAX_LEN) begin
          // buffer full: drop the sentence and hunt again
          too_long_seen = 1'b1;
          fill_pos = 0;
        end else begin
          line_buf[wr_slot][fill_pos] = rx;
          fill_pos++;
          if (rx == nsfq_pkg::END_CHAR) begin
            line_len[wr_slot] = fill_pos;
            r.done = 1'b1;
            r.length = fill_pos[nsfq_pkg::OUTLEN_W-1:0];
            wr_slot = (wr_slot + 1) % SLOTS;
            if (wr_slot == rd_slot) overflow_seen = 1'b1;
            fill_pos = 0;
          end
        end
      end
      nsfq_pkg::OP_READ: begin
        if (!was_empty && offset < line_len[rd_slot] && offset < MAX_LEN) begin
          r.valid = 1'b1;
          r.data = line_buf[rd_slot][offset];
        end
      end
      nsfq_pkg::OP_POP: begin
        if (!was_empty) rd_slot = (rd_slot + 1) % SLOTS;
      end
      default: ;
    endcase
    r.empty = (rd_slot == wr_slot);
    r.overflow = overflow_seen;
    r.too_long = too_long_seen;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Predict on every accepted command word, check every accepted result word
  always @(posedge clk) begin
    framer_result_t got;
    framer_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_framer(in_tuser, in_tdata[7:0], in_tdata[14:8]));
      if (out_tvalid && out_tready) begin
        checked_count++;
        got.done     = out_tuser[0];
        got.valid    = out_tuser[1];
        got.length   = out_tdata[6:0];
        got.data     = out_tdata[14:7];
        got.empty    = out_tdata[15];
        got.overflow = out_tdata[16];
        got.too_long = out_tdata[17];
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result word with nothing expected, actual %h", $time, got);
        end else begin
          want = expected_results.pop_front();
          check_field("sentence_done", want.done, got.done);
          check_field("sentence_length", want.length, got.length);
          check_field("read_data", want.data, got.data);
          check_field("read_valid", want.valid, got.valid);
          check_field("queue_empty", want.empty, got.empty);
          check_field("overflow_flag", want.overflow, got.overflow);
          check_field("too_long_flag", want.too_long, got.too_long);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // End the run when nothing moves for too long
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall_len;
    int burst_len;
    out_tready = 1'b0;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_active = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
      end else begin
        stall_len = receiver_calm ? 0 : gap_len();
        if (stall_len > 0) begin
          out_tready <= 1'b0;
          repeat (stall_len) @(posedge clk);
        end
      end
      burst_len = $urandom_range(1, 8);
      out_tready <= 1'b1;
      repeat (burst_len) @(posedge clk);
    end
  end

  // Offer one command word, wait for it to be taken
  task automatic send_word(input logic [1:0] op, input logic [7:0] rx, input logic [6:0] offset);
    int gap;
    gap = sender_calm ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, offset, rx};
    do @(posedge clk); while (!in_tready);
    sent_count++;
  endtask

  function automatic logic [7:0] body_char();
    logic [7:0] b;
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(8'h20, 8'h7E));
    b = 8'($urandom_range(0, 255));
    if (b == nsfq_pkg::END_CHAR) b = 8'h2A;
    return b;
  endfunction

  // Send '$', body_len body bytes and a line feed
  task automatic send_sentence(input int body_len);
    send_word(nsfq_pkg::OP_RX, nsfq_pkg::START_CHAR, 7'($urandom_range(0, 81)));
    for (int i = 0; i < body_len; i++)
      send_word(nsfq_pkg::OP_RX, body_char(), 7'($urandom_range(0, 81)));
    send_word(nsfq_pkg::OP_RX, nsfq_pkg::END_CHAR, 7'($urandom_range(0, 81)));
  endtask

  task automatic read_oldest(input logic [6:0] offset);
    send_word(nsfq_pkg::OP_READ, 8'($urandom_range(0, 255)), offset);
  endtask

  task automatic pop_oldest();
    send_word(nsfq_pkg::OP_POP, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 81)));
  endtask

  // Drop the offer and hold the sender until every result word has come back
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (checked_count != sent_count);
  endtask

  // Offsets mostly inside the oldest sentence, the rest anywhere in range
  function automatic logic [6:0] pick_offset();
    if (rd_slot != wr_slot && line_len[rd_slot] > 0 && $urandom_range(0, 3) != 0)
      return 7'($urandom_range(0, line_len[rd_slot] - 1));
    return 7'($urandom_range(0, 81));
  endfunction

  // Noise while hunting, spare op, and a pop and a read of an empty queue
  task automatic test_idle_commands();
    send_word(nsfq_pkg::OP_RX, nsfq_pkg::END_CHAR, 7'd0);
    send_word(nsfq_pkg::OP_RX, 8'h00, 7'd81);
    send_word(nsfq_pkg::OP_RX, 8'hFF, 7'd0);
    send_word(OP_NONE, 8'hFF, 7'd81);
    pop_oldest();
    read_oldest(7'd0);
    wait_all_results();
  endtask

  // Short sentence with a '$' inside, reads at the edges of its length
  task automatic test_short_sentence();
    send_word(nsfq_pkg::OP_RX, nsfq_pkg::START_CHAR, 7'd0);
    send_word(nsfq_pkg::OP_RX, 8'h41, 7'd0);
    send_word(nsfq_pkg::OP_RX, nsfq_pkg::START_CHAR, 7'd0);
    send_word(nsfq_pkg::OP_RX, nsfq_pkg::END_CHAR, 7'd0);
    read_oldest(7'd0);
    read_oldest(7'd3);
    read_oldest(7'd4);
    read_oldest(7'd81);
    pop_oldest();
    pop_oldest();
    wait_all_results();
  endtask

  // Sentence of exactly the buffer size
  task automatic test_longest_sentence();
    send_sentence(MAX_LEN - 2);
    read_oldest(7'(MAX_LEN - 1));
    read_oldest(7'd0);
    pop_oldest();
    wait_all_results();
  endtask

  // One byte more than the buffer holds: sentence dropped
  task automatic test_too_long();
    send_sentence(MAX_LEN - 1);
    read_oldest(7'd0);
    wait_all_results();
  endtask

  // Fill every slot so the write slot meets the read slot
  task automatic test_overflow();
    for (int i = 0; i < SLOTS; i++) send_sentence(0);
    read_oldest(7'd0);
    pop_oldest();
    send_sentence(2);
    read_oldest(7'd1);
    read_oldest(7'd3);
    pop_oldest();
    wait_all_results();
  endtask

  // Long receiver hold-off while words keep coming back to back
  task automatic test_back_pressure();
    hold_off_req = 1'b1;
    while (!hold_active) @(posedge clk);
    sender_calm = 1'b1;
    send_sentence(5);
    read_oldest(7'd2);
    send_sentence(5);
    read_oldest(7'd6);
    pop_oldest();
    send_sentence(3);
    sender_calm = 1'b0;
    wait_all_results();
  endtask

  // Mostly well-formed sentences, reads and pops; some noise and broken sentences
  task automatic test_random();
    int stop_at;
    int r;
    int body;
    stop_at = sent_count + RANDOM_WORDS;
    while (sent_count < stop_at) begin
      if ($urandom_range(0, 29) == 0) begin
        sender_calm = ($urandom_range(0, 2) == 0);
        receiver_calm = ($urandom_range(0, 2) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 38) begin
        body = $urandom_range(0, 99);
        if (body < 70) body = $urandom_range(0, 12);
        else if (body < 95) body = $urandom_range(13, 60);
        else body = $urandom_range(MAX_LEN - 4, MAX_LEN - 1);
        send_sentence(body);
      end else if (r < 68) begin
        repeat ($urandom_range(1, 4)) read_oldest(pick_offset());
      end else if (r < 84) begin
        pop_oldest();
      end else if (r < 93) begin
        send_word(nsfq_pkg::OP_RX, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 81)));
      end else if (r < 95) begin
        send_word(OP_NONE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 81)));
      end else if (r < 98) begin
        // broken sentence: start and a few bytes, no line feed
        send_word(nsfq_pkg::OP_RX, nsfq_pkg::START_CHAR, 7'($urandom_range(0, 81)));
        repeat ($urandom_range(0, 5))
          send_word(nsfq_pkg::OP_RX, body_char(), 7'($urandom_range(0, 81)));
      end else begin
        wait_all_results();
      end
    end
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
  endtask

  initial begin
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    rst_n     = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      line_len[s] = 0;
      for (int i = 0; i < MAX_LEN; i++) line_buf[s][i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_commands();
    test_short_sentence();
    test_longest_sentence();
    test_too_long();
    test_overflow();
    test_back_pressure();
    test_random();

    wait_all_results();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
